### rtl/core/pcwrl_pkg.sv
// pcwrl_pkg: shared constants, register map and result type for the
// per-client window rate limiter; no dependencies
package pcwrl_pkg;

	localparam int KEY_W     = 64;
	localparam int UID_W     = 16;
	localparam int TIME_W    = 32;
	localparam int CNT_W     = 17;
	localparam int LIMIT_W   = 16;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int S_TDATA_W = 112;
	localparam int M_TDATA_W = 16;

	localparam logic [KEY_W-1:0]   LOOPBACK_SALT  = 64'h9E3779B97F4A7C15;
	localparam logic [CNT_W-1:0]   CALL_COUNT_MAX = 17'h1FFFF;
	localparam logic [LIMIT_W-1:0] WINDOW_MIN     = 16'd100;
	localparam logic [LIMIT_W-1:0] WINDOW_MAX     = 16'd60000;

	localparam logic CMD_CALL  = 1'b0;
	localparam logic CMD_ERROR = 1'b1;

	localparam logic [1:0] REG_CALL_LIMIT = 2'd0;
	localparam logic [1:0] REG_WINDOW_MS  = 2'd1;
	localparam logic [1:0] REG_FLOOD_KICK = 2'd2;
	localparam logic [1:0] REG_ERROR_KICK = 2'd3;

	localparam logic [LIMIT_W-1:0] CALL_LIMIT_RST = 16'd64;
	localparam logic [LIMIT_W-1:0] WINDOW_MS_RST  = 16'd1000;

	typedef struct packed {
		logic [7:0] slot_index;
		logic       table_full;
		logic       disconnect;
		logic       over_limit;
		logic       allowed;
	} result_t;

endpackage

### rtl/core/pcwrl_ram.sv
// pcwrl_ram: generic single-write, single-read memory with registered read
// no dependencies
module pcwrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/pcwrl_hash.sv
// pcwrl_hash: home slot of a client key, key modulo the table size
// depends on pcwrl_pkg; power-of-two sizes take the low key bits, others a serial division
module pcwrl_hash #(
	parameter int TABLE_SLOTS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [pcwrl_pkg::KEY_W-1:0]      key,
	output logic                             done,
	output logic [$clog2(TABLE_SLOTS)-1:0]   home
);

	import pcwrl_pkg::*;

	localparam int  IW   = $clog2(TABLE_SLOTS);
	localparam int  RW   = IW + 1;
	localparam bit  POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

	generate
		if (POW2) begin : g_mask
			logic          done_q;
			logic [IW-1:0] home_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					home_q <= key[IW-1:0];
				end
			end

			assign done = done_q;
			assign home = home_q;
		end else begin : g_divide
			localparam logic [RW-1:0] N_RW = RW'(TABLE_SLOTS);

			logic             busy_q;
			logic             done_q;
			logic [2:0]       step_q;
			logic [KEY_W-1:0] key_q;
			logic [RW-1:0]    rem_q;
			logic [RW-1:0]    rem_next;

			// eight key bits per cycle, msb first, compare and subtract each
			always_comb begin
				rem_next = rem_q;
				for (int j = 0; j < 8; j++) begin
					rem_next = {rem_next[IW-1:0], key_q[KEY_W-1-j]};
					if (rem_next >= N_RW) begin
						rem_next = rem_next - N_RW;
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					busy_q <= 1'b0;
					done_q <= 1'b0;
					step_q <= '0;
				end else begin
					done_q <= busy_q && (step_q == 3'd7);
					if (start) begin
						busy_q <= 1'b1;
						step_q <= '0;
					end else if (busy_q) begin
						step_q <= step_q + 3'd1;
						if (step_q == 3'd7) begin
							busy_q <= 1'b0;
						end
					end
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					key_q <= key;
					rem_q <= '0;
				end else if (busy_q) begin
					key_q <= {key_q[KEY_W-9:0], 8'd0};
					rem_q <= rem_next;
				end
			end

			assign done = done_q;
			assign home = rem_q[IW-1:0];
		end
	endgenerate

endmodule

### rtl/core/per_client_window_rate_limiter_unit.sv
// per_client_window_rate_limiter_unit: top level, apb registers, probe
// sequencer and slot update; uses pcwrl_pkg, pcwrl_hash and pcwrl_ram
// flow: hash, then linear probing from the home slot until a matching or free
// slot is found or the table is full, then the result; unlimited calls skip the probe
// a new item is taken only in idle, after the previous result is handed on
// reset: a clearing pass writes every slot with tready low
module per_client_window_rate_limiter_unit #(
	parameter int TABLE_SLOTS = 256,
	parameter int ERROR_LIMIT = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// platform_id [63:0], local_user_id [79:64], now_ms [111:80]
	input  logic [pcwrl_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	// cmd [0]
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// allowed [0], over_limit [1], disconnect [2], table_full [3], slot_index [11:4]
	output logic [pcwrl_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pcwrl_pkg::PADDR_W-1:0]     paddr,
	input  logic [pcwrl_pkg::PDATA_W-1:0]     pwdata,
	output logic [pcwrl_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);

	import pcwrl_pkg::*;

	localparam int IW  = $clog2(TABLE_SLOTS);
	localparam int ECW = $clog2(ERROR_LIMIT + 1);
	localparam int EW  = 1 + KEY_W + TIME_W + CNT_W + ECW;

	localparam int EC_LO = 0;
	localparam int CC_LO = ECW;
	localparam int ST_LO = CC_LO + CNT_W;
	localparam int KY_LO = ST_LO + TIME_W;
	localparam int US_B  = KY_LO + KEY_W;

	localparam logic [ECW-1:0] ERR_LIM   = ECW'(ERROR_LIMIT);
	localparam logic [IW-1:0]  LAST_SLOT = IW'(TABLE_SLOTS - 1);
	localparam logic [IW:0]    N_TRIES   = (IW + 1)'(TABLE_SLOTS);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	// configuration
	logic [LIMIT_W-1:0] call_limit_q;
	logic [LIMIT_W-1:0] window_ms_q;
	logic               flood_kick_q;
	logic               error_kick_q;
	logic               cfg_wr;

	// control
	logic [2:0]        state_q;
	logic [IW-1:0]     clr_q;
	logic [IW-1:0]     probe_q;
	logic [IW:0]       tries_q;
	logic              m_valid_q;
	result_t           out_q;
	result_t           res_q;

	// item held during the probe
	logic              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] now_q;

	logic              accept;
	logic              unlimited;
	logic [KEY_W-1:0]  in_key;
	logic              hash_start;
	logic              hash_done;
	logic [IW-1:0]     hash_home;

	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [EW-1:0]     ram_wdata;
	logic              ram_re;
	logic [IW-1:0]     ram_raddr;
	logic [EW-1:0]     ram_rdata;

	logic              rd_used;
	logic [KEY_W-1:0]  rd_key;
	logic [TIME_W-1:0] rd_start;
	logic [CNT_W-1:0]  rd_cc;
	logic [ECW-1:0]    rd_ec;

	logic              hit;
	logic [IW-1:0]     probe_next;
	logic [LIMIT_W-1:0] win;
	logic [TIME_W-1:0] elapsed;
	logic              expired;
	logic [TIME_W-1:0] start_n;
	logic [CNT_W-1:0]  cc0;
	logic [CNT_W-1:0]  cc_n;
	logic [ECW-1:0]    ec0;
	logic [ECW-1:0]    ec_n;
	result_t           hit_res;
	result_t           full_res;
	result_t           unl_res;

	// apb registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			call_limit_q <= CALL_LIMIT_RST;
			window_ms_q  <= WINDOW_MS_RST;
			flood_kick_q <= 1'b1;
			error_kick_q <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_CALL_LIMIT: call_limit_q <= pwdata[LIMIT_W-1:0];
				REG_WINDOW_MS:  window_ms_q  <= pwdata[LIMIT_W-1:0];
				REG_FLOOD_KICK: flood_kick_q <= pwdata[0];
				REG_ERROR_KICK: error_kick_q <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CALL_LIMIT: prdata = PDATA_W'(call_limit_q);
			REG_WINDOW_MS:  prdata = PDATA_W'(window_ms_q);
			REG_FLOOD_KICK: prdata = PDATA_W'(flood_kick_q);
			REG_ERROR_KICK: prdata = PDATA_W'(error_kick_q);
			default:        prdata = '0;
		endcase
	end

	// input side
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign unlimited     = (s_axis_tuser == CMD_CALL) && (call_limit_q == '0);
	assign in_key        = (s_axis_tdata[KEY_W-1:0] != '0) ? s_axis_tdata[KEY_W-1:0]
		: (LOOPBACK_SALT ^ KEY_W'(s_axis_tdata[KEY_W+UID_W-1:KEY_W]));
	assign hash_start    = accept && !unlimited;

	pcwrl_hash #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (in_key),
		.done   (hash_done),
		.home   (hash_home)
	);

	// slot entry fields
	assign rd_used  = ram_rdata[US_B];
	assign rd_key   = ram_rdata[KY_LO +: KEY_W];
	assign rd_start = ram_rdata[ST_LO +: TIME_W];
	assign rd_cc    = ram_rdata[CC_LO +: CNT_W];
	assign rd_ec    = ram_rdata[EC_LO +: ECW];

	assign hit        = !rd_used || (rd_key == key_q);
	assign probe_next = (probe_q == LAST_SLOT) ? '0 : probe_q + 1'b1;

	// window restart and count update
	always_comb begin
		if (window_ms_q < WINDOW_MIN) begin
			win = WINDOW_MIN;
		end else if (window_ms_q > WINDOW_MAX) begin
			win = WINDOW_MAX;
		end else begin
			win = window_ms_q;
		end
		elapsed = now_q - rd_start;
		expired = (rd_start == '0) || (elapsed >= TIME_W'(win));
		start_n = expired ? now_q : rd_start;
		cc0     = expired ? '0 : rd_cc;
		ec0     = expired ? '0 : rd_ec;
		cc_n    = cc0;
		ec_n    = ec0;
		hit_res = '0;
		hit_res.slot_index = 8'(probe_q);
		if (cmd_q == CMD_CALL) begin
			if (cc0 < CALL_COUNT_MAX) begin
				cc_n = cc0 + 1'b1;
			end
			if (cc_n <= CNT_W'(call_limit_q)) begin
				hit_res.allowed = 1'b1;
			end else begin
				hit_res.over_limit = 1'b1;
				hit_res.disconnect = flood_kick_q;
			end
		end else begin
			if (ec0 < ERR_LIM) begin
				ec_n = ec0 + 1'b1;
			end
			if (ec_n >= ERR_LIM) begin
				hit_res.over_limit = 1'b1;
				hit_res.disconnect = error_kick_q;
			end
		end
	end

	always_comb begin
		full_res            = '0;
		full_res.table_full = 1'b1;
		full_res.allowed    = (cmd_q == CMD_CALL);
		unl_res             = '0;
		unl_res.allowed     = 1'b1;
	end

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = probe_q;
		ram_wdata = {1'b1, key_q, start_n, cc_n, ec_n};
		ram_re    = 1'b0;
		ram_raddr = probe_next;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_HASH: begin
				ram_re    = hash_done;
				ram_raddr = hash_home;
			end
			ST_CHECK: begin
				ram_we = hit;
				ram_re = !hit && (tries_q != N_TRIES);
			end
			default: begin
			end
		endcase
	end

	pcwrl_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			probe_q   <= '0;
			tries_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && (!m_valid_q || m_axis_tready)) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= unlimited ? ST_EMIT : ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						probe_q <= hash_home;
						tries_q <= (IW + 1)'(1);
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (hit || (tries_q == N_TRIES)) begin
						state_q <= ST_EMIT;
					end else begin
						probe_q <= probe_next;
						tries_q <= tries_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (!m_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_axis_tuser;
			key_q <= in_key;
			now_q <= s_axis_tdata[KEY_W+UID_W +: TIME_W];
			res_q <= unl_res;
		end
		if (state_q == ST_CHECK) begin
			if (hit) begin
				res_q <= hit_res;
			end else if (tries_q == N_TRIES) begin
				res_q <= full_res;
			end
		end
		if ((state_q == ST_EMIT) && (!m_valid_q || m_axis_tready)) begin
			out_q <= res_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = M_TDATA_W'(out_q);

endmodule
